[sv/hsn_pkg.sv]
// Shared constants and types for the heightmap Sobel normal stream unit.
// No dependencies; used by hsn_norm and heightmap_sobel_normal_stream_unit.
package hsn_pkg;

	localparam int MAX_WIDTH = 1024;
	localparam int ADDR_W    = $clog2(MAX_WIDTH);
	localparam int FRAC_BITS = 14;

	// Configuration register indexes.
	localparam logic [1:0] CFG_MAP_WIDTH    = 2'd0;
	localparam logic [1:0] CFG_MAP_HEIGHT   = 2'd1;
	localparam logic [1:0] CFG_HEIGHT_SCALE = 2'd2;

	// One normal to compute: three window columns of {below, centre, above} bytes.
	typedef struct packed {
		logic [15:0] row;
		logic [9:0]  col;
		logic [23:0] left;
		logic [23:0] mid;
		logic [23:0] right;
		logic        top;
		logic        bottom;
		logic        last;
	} job_t;

	typedef struct packed {
		logic [15:0] row;
		logic [9:0]  col;
		logic [15:0] nx;
		logic [14:0] ny;
		logic [15:0] nz;
		logic        last;
	} res_t;

endpackage

[sv/hsn_ram.sv]
// Generic single-port-write, single-port-read synchronous RAM.
// Read data is registered. No dependencies.
module hsn_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[sv/hsn_norm.sv]
// Normal unit: Sobel gradients, squared length, iterative square root and
// three iterative rounded divisions. Depends on hsn_pkg.
module hsn_norm (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  hsn_pkg::job_t job,
	input  logic [15:0]   scale,
	output logic          busy,
	output logic          res_valid,
	output hsn_pkg::res_t res,
	input  logic          ack
);

	localparam logic [3:0] N_IDLE = 4'd0;
	localparam logic [3:0] N_RAW  = 4'd1;
	localparam logic [3:0] N_MUL  = 4'd2;
	localparam logic [3:0] N_SQ   = 4'd3;
	localparam logic [3:0] N_SUM  = 4'd4;
	localparam logic [3:0] N_NORM = 4'd5;
	localparam logic [3:0] N_SQRT = 4'd6;
	localparam logic [3:0] N_DSET = 4'd7;
	localparam logic [3:0] N_DIV  = 4'd8;
	localparam logic [3:0] N_DEND = 4'd9;
	localparam logic [3:0] N_DONE = 4'd10;

	localparam logic [1:0] SEL_X = 2'd0;
	localparam logic [1:0] SEL_Y = 2'd1;
	localparam logic [1:0] SEL_Z = 2'd2;

	logic [3:0]         state_q;
	hsn_pkg::job_t      job_q;
	logic signed [11:0] rgx_q, rgz_q;
	logic signed [27:0] gx_q, gz_q;
	logic [53:0]        sqx_q, sqz_q;
	logic [61:0]        d_q;
	logic [4:0]         k_q;
	logic [61:0]        v_q;
	logic [62:0]        root_q;
	logic [62:0]        bit_q;
	logic [1:0]         sel_q;
	logic [47:0]        rem_q;
	logic [3:0]         i_q;
	logic [15:0]        q_q;
	logic               neg_q;
	logic [15:0]        nx_q, nz_q;
	logic [14:0]        ny_q;

	// Window bytes, with the top or bottom row replaced by the centre height when its flag is set.
	logic [7:0]  al, ac, ar, cl, cc, cr, bl, bc, br;
	logic [11:0] a_sum, b_sum, l_sum, r_sum;
	always_comb begin
		cl = job_q.left[15:8];
		cc = job_q.mid[15:8];
		cr = job_q.right[15:8];
		al = job_q.top ? cc : job_q.left[7:0];
		ac = job_q.top ? cc : job_q.mid[7:0];
		ar = job_q.top ? cc : job_q.right[7:0];
		bl = job_q.bottom ? cc : job_q.left[23:16];
		bc = job_q.bottom ? cc : job_q.mid[23:16];
		br = job_q.bottom ? cc : job_q.right[23:16];
		a_sum = {4'b0, al} + {3'b0, ac, 1'b0} + {4'b0, ar};
		b_sum = {4'b0, bl} + {3'b0, bc, 1'b0} + {4'b0, br};
		l_sum = {4'b0, al} + {3'b0, cl, 1'b0} + {4'b0, bl};
		r_sum = {4'b0, ar} + {3'b0, cr, 1'b0} + {4'b0, br};
	end

	logic signed [16:0] scale_s;
	logic signed [28:0] prod_x, prod_z;
	logic [27:0]        absx, absz;
	logic [26:0]        magx, magz, mag;
	logic [30:0]        len;
	logic [5:0]         shamt;
	logic [47:0]        num;
	logic [62:0]        trial_sq;
	logic [47:0]        trial_div;
	logic               ge;
	logic [15:0]        q_neg;

	always_comb begin
		scale_s   = $signed({1'b0, scale});
		prod_x    = rgx_q * scale_s;
		prod_z    = rgz_q * scale_s;
		absx      = gx_q[27] ? (~gx_q + 28'd1) : gx_q;
		absz      = gz_q[27] ? (~gz_q + 28'd1) : gz_q;
		magx      = absx[26:0];
		magz      = absz[26:0];
		len       = root_q[30:0];
		case (sel_q)
			SEL_X:   mag = magx;
			SEL_Y:   mag = 27'd256;
			default: mag = magz;
		endcase
		shamt     = 6'(hsn_pkg::FRAC_BITS) + {1'b0, k_q};
		num       = {21'b0, mag} << shamt;
		trial_sq  = root_q + bit_q;
		trial_div = {16'b0, len, 1'b0} << i_q;
		ge        = rem_q >= trial_div;
		q_neg     = ~q_q + 16'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= N_IDLE;
		end else begin
			case (state_q)
				N_IDLE: begin
					if (start) begin
						state_q <= N_RAW;
					end
				end
				N_RAW:  state_q <= N_MUL;
				N_MUL:  state_q <= N_SQ;
				N_SQ:   state_q <= N_SUM;
				N_SUM:  state_q <= N_NORM;
				N_NORM: begin
					if (d_q[61:60] != 2'b00) begin
						state_q <= N_SQRT;
					end
				end
				N_SQRT: begin
					if (bit_q == 63'd1) begin
						state_q <= N_DSET;
					end
				end
				N_DSET: state_q <= N_DIV;
				N_DIV: begin
					if (i_q == 4'd0) begin
						state_q <= N_DEND;
					end
				end
				N_DEND: state_q <= (sel_q == SEL_Z) ? N_DONE : N_DSET;
				N_DONE: begin
					if (ack) begin
						state_q <= N_IDLE;
					end
				end
				default: state_q <= N_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			N_IDLE: begin
				if (start) begin
					job_q <= job;
				end
			end
			N_RAW: begin
				rgx_q <= $signed(b_sum) - $signed(a_sum);
				rgz_q <= $signed(r_sum) - $signed(l_sum);
			end
			N_MUL: begin
				gx_q <= prod_x[27:0];
				gz_q <= prod_z[27:0];
			end
			N_SQ: begin
				sqx_q <= magx * magx;
				sqz_q <= magz * magz;
			end
			N_SUM: begin
				d_q <= {8'b0, sqx_q} + {8'b0, sqz_q} + 62'd65536;
				k_q <= '0;
			end
			N_NORM: begin
				if (d_q[61:60] == 2'b00) begin
					d_q <= {d_q[59:0], 2'b00};
					k_q <= k_q + 5'd1;
				end else begin
					v_q    <= d_q;
					root_q <= '0;
					bit_q  <= 63'd1 << 62;
				end
			end
			N_SQRT: begin
				if ({1'b0, v_q} >= trial_sq) begin
					v_q    <= v_q - trial_sq[61:0];
					root_q <= (root_q >> 1) + bit_q;
				end else begin
					root_q <= root_q >> 1;
				end
				bit_q <= bit_q >> 2;
				sel_q <= SEL_X;
			end
			N_DSET: begin
				// Rounded quotient: (2*num + len) / (2*len), ties away from zero.
				rem_q <= {num[46:0], 1'b0} + {17'b0, len};
				q_q   <= '0;
				i_q   <= 4'd15;
				case (sel_q)
					SEL_X:   neg_q <= gx_q[27];
					SEL_Y:   neg_q <= 1'b0;
					default: neg_q <= gz_q[27];
				endcase
			end
			N_DIV: begin
				if (ge) begin
					rem_q <= rem_q - trial_div;
				end
				q_q <= {q_q[14:0], ge};
				i_q <= i_q - 4'd1;
			end
			N_DEND: begin
				case (sel_q)
					SEL_X:   nx_q <= neg_q ? q_neg : q_q;
					SEL_Y:   ny_q <= q_q[14:0];
					default: nz_q <= neg_q ? q_neg : q_q;
				endcase
				sel_q <= sel_q + 2'd1;
			end
			default: begin
			end
		endcase
	end

	assign busy      = state_q != N_IDLE;
	assign res_valid = state_q == N_DONE;
	assign res.row   = job_q.row;
	assign res.col   = job_q.col;
	assign res.nx    = nx_q;
	assign res.ny    = ny_q;
	assign res.nz    = nz_q;
	assign res.last  = job_q.last;

endmodule

[sv/heightmap_sobel_normal_stream_unit.sv]
// Top level of the heightmap Sobel normal stream: line memories, window,
// raster counters and output register. Depends on hsn_pkg, hsn_ram, hsn_norm.
//
//   channel | signals                                   | flow
//   --------+-------------------------------------------+---------------------
//   input   | in_valid, in_stall, kind, height          | item in, valid/stall
//   output  | out_valid, out_stall, out_row .. frame_last| item out, valid/stall
//   config  | cfg_we, cfg_index, cfg_data               | write only
//
// One item is worked on at a time and the input stalls meanwhile. Each normal
// an item yields takes up to 22 normalise steps, 32 square root steps and
// three divisions. Reset clears counters, window and the output valid flag;
// the line memories hold no reset value. A stalled output holds its item in
// the output register; a further normal then waits in the normal unit and the
// input stays stalled.
module heightmap_sobel_normal_stream_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               kind,
	input  logic [7:0]         height,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [15:0]        out_row,
	output logic [9:0]         out_col,
	output logic signed [15:0] normal_x,
	output logic [14:0]        normal_y,
	output logic signed [15:0] normal_z,
	output logic               frame_last,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_RD   = 4'd1;
	localparam logic [3:0] ST_WR   = 4'd2;
	localparam logic [3:0] ST_J2   = 4'd3;
	localparam logic [3:0] ST_GO   = 4'd4;
	localparam logic [3:0] ST_WAIT = 4'd5;
	localparam logic [3:0] ST_FM   = 4'd6;
	localparam logic [3:0] ST_FL   = 4'd7;
	localparam logic [3:0] ST_FR   = 4'd8;
	localparam logic [3:0] ST_FC   = 4'd9;

	localparam int AW = hsn_pkg::ADDR_W;

	logic [3:0]    state_q;
	logic [10:0]   width_q;
	logic [15:0]   height_q;
	logic [15:0]   scale_q;
	logic [15:0]   row_q;
	logic [AW-1:0] col_q;
	logic [AW-1:0] flush_q;
	logic [23:0]   w1_q, w2_q;
	logic [AW-1:0] c_q;
	logic [15:0]   r_q;
	logic [7:0]    hv_q;
	logic          pend2_q;
	logic          f_last_q;
	logic [15:0]   mid_q, left_q;
	hsn_pkg::job_t job_q;

	logic          out_valid_q;
	hsn_pkg::res_t out_q;

	// Effective width in [2, MAX_WIDTH] and height of at least 2.
	logic [10:0]   eff_w, w_m1;
	logic [15:0]   eff_h;
	always_comb begin
		if (width_q < 11'd2) begin
			eff_w = 11'd2;
		end else if (width_q > 11'(hsn_pkg::MAX_WIDTH)) begin
			eff_w = 11'(hsn_pkg::MAX_WIDTH);
		end else begin
			eff_w = width_q;
		end
		eff_h = (height_q < 16'd2) ? 16'd2 : height_q;
		w_m1  = eff_w - 11'd1;
	end

	logic          in_acc;
	logic          frame_done;
	logic [AW-1:0] col_eff, c_in, k_in;
	assign in_stall   = state_q != ST_IDLE;
	assign in_acc     = in_valid && !in_stall;
	assign frame_done = row_q >= eff_h;
	assign col_eff    = frame_done ? '0 : col_q;
	assign c_in       = ({1'b0, col_eff} >= eff_w) ? w_m1[AW-1:0] : col_eff;
	assign k_in       = ({1'b0, flush_q} >= eff_w) ? w_m1[AW-1:0] : flush_q;

	// Line memories: rows r-2 and r-1 of the current column.
	logic          line_we;
	logic [AW-1:0] raddr;
	logic [7:0]    above_rd, cur_rd;
	assign line_we = state_q == ST_WR;
	always_comb begin
		case (state_q)
			ST_FM:   raddr = job_q.col;
			ST_FL:   raddr = job_q.col - AW'(1);
			ST_FR:   raddr = job_q.col + AW'(1);
			default: raddr = c_q;
		endcase
	end

	hsn_ram #(.WIDTH(8), .DEPTH(hsn_pkg::MAX_WIDTH)) u_above (
		.clk   (clk),
		.we    (line_we),
		.waddr (c_q),
		.wdata (cur_rd),
		.raddr (raddr),
		.rdata (above_rd)
	);

	hsn_ram #(.WIDTH(8), .DEPTH(hsn_pkg::MAX_WIDTH)) u_current (
		.clk   (clk),
		.we    (line_we),
		.waddr (c_q),
		.wdata (hv_q),
		.raddr (raddr),
		.rdata (cur_rd)
	);

	// Normals of a sample item: the one left of it, and its own at the row end.
	logic [23:0]   new_col;
	logic          j1, j2, c_last;
	hsn_pkg::job_t job1, job2, fjob;
	always_comb begin
		new_col     = {hv_q, cur_rd, above_rd};
		c_last      = {1'b0, c_q} == w_m1;
		j1          = (r_q != 16'd0) && (c_q != '0);
		j2          = (r_q != 16'd0) && c_last;
		job1.row    = r_q - 16'd1;
		job1.col    = c_q - AW'(1);
		job1.left   = (c_q == AW'(1)) ? w2_q : w1_q;
		job1.mid    = w2_q;
		job1.right  = new_col;
		job1.top    = r_q == 16'd1;
		job1.bottom = 1'b0;
		job1.last   = 1'b0;
		job2.row    = r_q - 16'd1;
		job2.col    = c_q;
		job2.left   = w1_q;
		job2.mid    = w2_q;
		job2.right  = w2_q;
		job2.top    = r_q == 16'd1;
		job2.bottom = 1'b0;
		job2.last   = 1'b0;
		fjob.row    = eff_h - 16'd1;
		fjob.col    = job_q.col;
		fjob.mid    = {8'b0, mid_q};
		fjob.left   = (job_q.col != '0) ? {8'b0, left_q} : {8'b0, mid_q};
		fjob.right  = f_last_q ? {8'b0, mid_q} : {8'b0, cur_rd, above_rd};
		fjob.top    = 1'b0;
		fjob.bottom = 1'b1;
		fjob.last   = f_last_q;
	end

	logic          norm_start, norm_busy, norm_valid, res_ack;
	hsn_pkg::res_t norm_res;
	assign norm_start = state_q == ST_GO;
	assign res_ack    = norm_valid && (!out_valid_q || !out_stall);

	hsn_norm u_norm (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (norm_start),
		.job       (job_q),
		.scale     (scale_q),
		.busy      (norm_busy),
		.res_valid (norm_valid),
		.res       (norm_res),
		.ack       (res_ack)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 11'd256;
			height_q <= 16'd256;
			scale_q  <= 16'd256;
		end else if (cfg_we) begin
			case (cfg_index)
				hsn_pkg::CFG_MAP_WIDTH:    width_q  <= cfg_data[10:0];
				hsn_pkg::CFG_MAP_HEIGHT:   height_q <= cfg_data;
				hsn_pkg::CFG_HEIGHT_SCALE: scale_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			row_q    <= '0;
			col_q    <= '0;
			flush_q  <= '0;
			w1_q     <= '0;
			w2_q     <= '0;
			pend2_q  <= 1'b0;
			f_last_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (!kind) begin
							// A sample after the last row starts a new frame.
							if (frame_done) begin
								row_q   <= '0;
								flush_q <= '0;
							end
							state_q <= ST_RD;
						end else if (frame_done) begin
							f_last_q <= {1'b0, k_in} == w_m1;
							state_q  <= ST_FM;
						end
					end
				end
				ST_RD: state_q <= ST_WR;
				ST_WR: begin
					w1_q <= w2_q;
					w2_q <= new_col;
					if (c_last) begin
						col_q <= '0;
						row_q <= r_q + 16'd1;
					end else begin
						col_q <= c_q + AW'(1);
					end
					pend2_q <= j1 && j2;
					if (j1) begin
						state_q <= ST_GO;
					end else if (j2) begin
						state_q <= ST_J2;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_J2: begin
					pend2_q <= 1'b0;
					state_q <= ST_GO;
				end
				ST_GO: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (res_ack) begin
						state_q <= pend2_q ? ST_J2 : ST_IDLE;
					end
				end
				ST_FM: state_q <= ST_FL;
				ST_FL: state_q <= ST_FR;
				ST_FR: state_q <= ST_FC;
				ST_FC: begin
					if (f_last_q) begin
						row_q   <= '0;
						col_q   <= '0;
						flush_q <= '0;
					end else begin
						flush_q <= job_q.col + AW'(1);
					end
					pend2_q <= 1'b0;
					state_q <= ST_GO;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Item and job payload registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					c_q       <= c_in;
					r_q       <= frame_done ? 16'd0 : row_q;
					hv_q      <= height;
					job_q.col <= k_in;
				end
			end
			ST_WR: begin
				if (j1) begin
					job_q <= job1;
				end
			end
			ST_J2:   job_q <= job2;
			ST_FL:   mid_q <= {cur_rd, above_rd};
			ST_FR:   left_q <= {cur_rd, above_rd};
			ST_FC:   job_q <= fjob;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ack) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ack) begin
			out_q <= norm_res;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_row    = out_q.row;
	assign out_col    = out_q.col;
	assign normal_x   = $signed(out_q.nx);
	assign normal_y   = out_q.ny;
	assign normal_z   = $signed(out_q.nz);
	assign frame_last = out_q.last;

`ifndef NO_ASSERTIONS
	a_idle_norm_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (!norm_busy && !norm_valid))
		else $error("normal unit still busy while the block takes items");

	a_flush_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FC && f_last_q) |=> (row_q == 16'd0 && col_q == '0 && flush_q == '0))
		else $error("counters not cleared after the final flush item");

	a_wait_has_job: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_GO) |=> norm_busy)
		else $error("normal unit did not take its job");
`endif

endmodule

[dv/heightmap_sobel_normal_stream_unit_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench for heightmap_sobel_normal_stream_unit: predicts every normal
// from the accepted samples and flush ticks and checks the output stream in order.
// Depends on hsn_pkg and the unit's RTL only.
module heightmap_sobel_normal_stream_unit_tb;

	localparam int CYCLE_LIMIT = 4000000;
	localparam int SETTLE      = 300;

	// Holds the predicted normals and the raster state that produces them.
	class normal_scoreboard;
		logic [7:0]  above_line [hsn_pkg::MAX_WIDTH];
		logic [7:0]  cur_line [hsn_pkg::MAX_WIDTH];
		logic [23:0] win [3];
		int unsigned row_n, col_n, flush_n;
		int unsigned width_reg, height_reg, scale_reg;
		hsn_pkg::res_t normal_q [$];
		int          errors;

		function new();
			foreach (above_line[i]) begin
				above_line[i] = '0;
				cur_line[i]   = '0;
			end
			foreach (win[i])
				win[i] = '0;
			row_n = 0; col_n = 0; flush_n = 0;
			width_reg = 256; height_reg = 256; scale_reg = 256;
			errors = 0;
		endfunction

		function int unsigned eff_w();
			if (width_reg < 2)
				return 2;
			if (width_reg > hsn_pkg::MAX_WIDTH)
				return hsn_pkg::MAX_WIDTH;
			return width_reg;
		endfunction

		function int unsigned eff_h();
			return height_reg < 2 ? 2 : height_reg;
		endfunction

		function bit last_row_waiting();
			return row_n >= eff_h();
		endfunction

		function int pending();
			return normal_q.size();
		endfunction

		function void write_reg(logic [1:0] idx, logic [15:0] val);
			case (idx)
				hsn_pkg::CFG_MAP_WIDTH:    width_reg = val[10:0];
				hsn_pkg::CFG_MAP_HEIGHT:   height_reg = val;
				hsn_pkg::CFG_HEIGHT_SCALE: scale_reg = val;
				default: ;
			endcase
		endfunction

		function longint px(logic [23:0] c, int pos);
			return longint'({56'b0, c[8*pos +: 8]}) * longint'(scale_reg);
		endfunction

		function longint unsigned isqrt(longint unsigned v);
			longint unsigned res, b;
			res = 0;
			b = 64'd1 << 62;
			while (b > v)
				b = b >> 2;
			while (b != 0) begin
				if (v >= res + b) begin
					v = v - (res + b);
					res = (res >> 1) + b;
				end else
					res = res >> 1;
				b = b >> 2;
			end
			return res;
		endfunction

		// Rounds g * 2^(FRAC_BITS+k) / len to nearest, ties away from zero.
		function logic [63:0] unit_comp(longint g, int unsigned k, longint unsigned len);
			longint unsigned mag, q;
			mag = g < 0 ? longint'(-g) : g;
			q = (2 * (mag << (hsn_pkg::FRAC_BITS + k)) + len) / (2 * len);
			return g < 0 ? -q : q;
		endfunction

		function void add_normal(int unsigned row, int unsigned col, logic [23:0] l,
				logic [23:0] m, logic [23:0] r, bit top, bit bottom, bit last);
			longint al, ac, ar, cl, cc, cr, bl, bc, br, gx, gz;
			longint unsigned d, len;
			int unsigned k;
			hsn_pkg::res_t e;
			al = px(l, 0); ac = px(m, 0); ar = px(r, 0);
			cl = px(l, 1); cc = px(m, 1); cr = px(r, 1);
			bl = px(l, 2); bc = px(m, 2); br = px(r, 2);
			if (top) begin
				al = cc; ac = cc; ar = cc;
			end
			if (bottom) begin
				bl = cc; bc = cc; br = cc;
			end
			gx = (bl + 2 * bc + br) - (al + 2 * ac + ar);
			gz = (ar + 2 * cr + br) - (al + 2 * cl + bl);
			d = gx * gx + gz * gz + 65536;
			k = 0;
			while (d < (64'd1 << 60)) begin
				d = d << 2;
				k++;
			end
			len = isqrt(d);
			e.row  = row[15:0];
			e.col  = col[9:0];
			e.nx   = 16'(unit_comp(gx, k, len));
			e.ny   = 15'(unit_comp(256, k, len));
			e.nz   = 16'(unit_comp(gz, k, len));
			e.last = last;
			normal_q = {normal_q, e};
		endfunction

		function void note_item(bit is_flush, logic [7:0] hv);
			int unsigned w, h, c, r, fk;
			logic [23:0] colw, mid, lft, rgt;
			w = eff_w();
			h = eff_h();
			if (!is_flush) begin
				if (row_n >= h) begin
					row_n = 0; col_n = 0; flush_n = 0;
				end
				c = col_n >= w ? w - 1 : col_n;
				r = row_n;
				colw = {hv, cur_line[c], above_line[c]};
				win[0] = win[1];
				win[1] = win[2];
				win[2] = colw;
				above_line[c] = cur_line[c];
				cur_line[c] = hv;
				if (r >= 1) begin
					if (c >= 1)
						add_normal(r - 1, c - 1, c == 1 ? win[1] : win[0], win[1], win[2],
							r == 1, 1'b0, 1'b0);
					if (c == w - 1)
						add_normal(r - 1, c, win[1], win[2], win[2], r == 1, 1'b0, 1'b0);
				end
				if (c == w - 1) begin
					col_n = 0;
					row_n = r + 1;
				end else
					col_n = c + 1;
			end else if (row_n >= h) begin
				fk = flush_n >= w ? w - 1 : flush_n;
				mid = {8'h00, cur_line[fk], above_line[fk]};
				lft = mid;
				rgt = mid;
				if (fk > 0)
					lft = {8'h00, cur_line[fk - 1], above_line[fk - 1]};
				if (fk != w - 1)
					rgt = {8'h00, cur_line[fk + 1], above_line[fk + 1]};
				add_normal(h - 1, fk, lft, mid, rgt, 1'b0, 1'b1, fk == w - 1);
				if (fk == w - 1) begin
					row_n = 0; col_n = 0; flush_n = 0;
				end else
					flush_n = fk + 1;
			end
		endfunction

		function void check_normal(hsn_pkg::res_t got);
			hsn_pkg::res_t e;
			if (normal_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected normal row %0d col %0d", got.row, got.col);
				return;
			end
			e = normal_q.pop_front();
			if (got.row !== e.row || got.col !== e.col || got.nx !== e.nx
					|| got.ny !== e.ny || got.nz !== e.nz || got.last !== e.last) begin
				errors++;
				if (errors <= 10)
					$display("normal mismatch: exp r%0d c%0d x%h y%h z%h l%b, got r%0d c%0d x%h y%h z%h l%b",
						e.row, e.col, e.nx, e.ny, e.nz, e.last,
						got.row, got.col, got.nx, got.ny, got.nz, got.last);
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic               kind;
	logic [7:0]         height;
	logic               out_valid;
	logic               out_stall;
	logic [15:0]        out_row;
	logic [9:0]         out_col;
	logic signed [15:0] normal_x;
	logic [14:0]        normal_y;
	logic signed [15:0] normal_z;
	logic               frame_last;
	logic               cfg_we;
	logic [1:0]         cfg_index;
	logic [15:0]        cfg_data;

	normal_scoreboard sb;
	bit  idle_on;
	bit  calm;
	bit  hold_req;
	int  hold_left;
	int  stall_left;
	int  cycles;

	heightmap_sobel_normal_stream_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .kind(kind), .height(height),
		.out_valid(out_valid), .out_stall(out_stall), .out_row(out_row),
		.out_col(out_col), .normal_x(normal_x), .normal_y(normal_y),
		.normal_z(normal_z), .frame_last(frame_last),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Output side: checks each accepted normal and decides the next stall.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_normal('{row: out_row, col: out_col, nx: normal_x, ny: normal_y,
				nz: normal_z, last: frame_last});
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = 3000;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (idle_on && !calm && $urandom_range(0, 9) == 0) begin
			stall_left = $urandom_range(0, 7);
			out_stall <= 1'b1;
		end else
			out_stall <= 1'b0;
	end

	task automatic put_item(bit is_flush, logic [7:0] hv);
		if (idle_on && !calm && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= is_flush;
		height <= hv;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_item(is_flush, hv);
	endtask

	function automatic logic [7:0] pick_height();
		case ($urandom_range(0, 7))
			0: return 8'd0;
			1: return 8'd255;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// Mostly well-formed raster: samples, then flushes once the last row is due.
	task automatic next_item();
		if (sb.last_row_waiting()) begin
			if ($urandom_range(0, 11) == 0)
				put_item(1'b0, pick_height());
			else
				put_item(1'b1, 8'd0);
		end else if ($urandom_range(0, 29) == 0)
			put_item(1'b1, pick_height());
		else
			put_item(1'b0, pick_height());
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(idx, val);
	endtask

	task automatic finish_frame();
		while (!(sb.row_n == 0 && sb.col_n == 0)) begin
			if (sb.last_row_waiting())
				put_item(1'b1, 8'd0);
			else
				put_item(1'b0, pick_height());
		end
	endtask

	// The line memories must never be read past the width used so far in a
	// frame, so a wider setting waits for the frame to end.
	task automatic set_phase(logic [15:0] w, logic [15:0] h, logic [15:0] s);
		int unsigned new_w;
		new_w = w < 2 ? 2 : (w > hsn_pkg::MAX_WIDTH ? hsn_pkg::MAX_WIDTH : w);
		drain();
		write_reg(hsn_pkg::CFG_HEIGHT_SCALE, s);
		if (new_w <= sb.eff_w()) begin
			write_reg(hsn_pkg::CFG_MAP_WIDTH, w);
			write_reg(hsn_pkg::CFG_MAP_HEIGHT, h);
		end else begin
			write_reg(hsn_pkg::CFG_MAP_HEIGHT, 16'd2);
			finish_frame();
			drain();
			write_reg(hsn_pkg::CFG_MAP_HEIGHT, h);
			write_reg(hsn_pkg::CFG_MAP_WIDTH, w);
		end
	endtask

	initial begin
		logic [15:0] w, h, s;
		int n;
		sb = new();
		arst_n = 1'b0;
		in_valid <= 1'b0;
		kind <= 1'b0;
		height <= 8'd0;
		out_stall <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= hsn_pkg::CFG_MAP_WIDTH;
		cfg_data <= 16'd0;
		idle_on = 1'b1;
		calm = 1'b0;
		hold_req = 1'b0;
		hold_left = 0;
		stall_left = 0;
		cycles = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: a 3x2 frame with extreme heights, its flush and a stray flush.
		write_reg(hsn_pkg::CFG_MAP_WIDTH, 16'd3);
		write_reg(hsn_pkg::CFG_MAP_HEIGHT, 16'd2);
		write_reg(hsn_pkg::CFG_HEIGHT_SCALE, 16'd256);
		put_item(1'b0, 8'd255); put_item(1'b0, 8'd0);   put_item(1'b0, 8'd255);
		put_item(1'b0, 8'd0);   put_item(1'b0, 8'd255); put_item(1'b0, 8'd0);
		repeat (3) put_item(1'b1, 8'd0);
		put_item(1'b1, 8'd170);

		// Full scale, then the width shrinks in the middle of a row, and a
		// sample arrives while the last row is only partly flushed.
		drain();
		write_reg(hsn_pkg::CFG_MAP_WIDTH, 16'd5);
		write_reg(hsn_pkg::CFG_HEIGHT_SCALE, 16'hffff);
		put_item(1'b0, 8'd255); put_item(1'b0, 8'd255); put_item(1'b0, 8'd0);
		put_item(1'b0, 8'd128); put_item(1'b0, 8'd1);
		put_item(1'b0, 8'd255); put_item(1'b0, 8'd0);   put_item(1'b0, 8'd77);
		drain();
		write_reg(hsn_pkg::CFG_MAP_WIDTH, 16'd2);
		put_item(1'b0, 8'd200);
		put_item(1'b1, 8'd0);
		put_item(1'b0, 8'd9);

		for (int p = 0; p < 10; p++) begin
			if (p == 0) begin
				w = 16'd2047; h = 16'd2; s = 16'($urandom_range(0, 65535)); n = 300;
			end else begin
				case ($urandom_range(0, 5))
					0: w = 16'd0;
					1: w = 16'd1;
					default: w = 16'($urandom_range(2, 12));
				endcase
				case ($urandom_range(0, 5))
					0: h = 16'd0;
					1: h = 16'd1;
					2: h = 16'hffff;
					default: h = 16'($urandom_range(2, 6));
				endcase
				case ($urandom_range(0, 3))
					0: s = 16'd0;
					1: s = 16'hffff;
					default: s = 16'($urandom_range(0, 65535));
				endcase
				n = 30;
			end
			set_phase(w, h, s);
			idle_on = (p % 3) != 2;
			calm = (p == 9);
			if (p == 1)
				hold_req = 1'b1;
			repeat (n) next_item();
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
